@@ design/lrmms_pkg.sv @@
// ----------------------------------------------------------------------------
// lrmms_pkg
// Types and constants shared by the lane row statistics block.
// ----------------------------------------------------------------------------
package lrmms_pkg;

	localparam int WORD_W    = 32;
	localparam int SUM_W     = 64;
	localparam int LANE_W    = 4;
	localparam int BEAT_W    = 26;
	localparam int MAX_LANES = 16;
	localparam int MEM_DEPTH = 2 * MAX_LANES;
	localparam int ADDR_W    = LANE_W + 1;
	localparam int OUT_W     = 136;

	typedef struct packed {
		logic [SUM_W-1:0]  sum;
		logic [WORD_W-1:0] min;
		logic [WORD_W-1:0] max;
	} stat_t;

	localparam stat_t STAT_RESET = '{sum: '0, min: '1, max: '0};

	// Handoff from the update pipeline to the drain sequencer at row end.
	typedef struct packed {
		logic vld;
		logic bank;
		logic eop;
	} drain_start_t;

endpackage

@@ design/lrmms_stat_mem.sv @@
// ----------------------------------------------------------------------------
// lrmms_stat_mem
// Two-bank statistics memory: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module lrmms_stat_mem (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   clr_en,
	input  logic                   clr_bank,
	input  logic                   wr_en,
	input  logic [lrmms_pkg::ADDR_W-1:0] wr_addr,
	input  lrmms_pkg::stat_t       wr_data,
	input  logic                   rd1_en,
	input  logic [lrmms_pkg::ADDR_W-1:0] rd1_addr,
	output lrmms_pkg::stat_t       rd1_data,
	input  logic                   rd2_en,
	input  logic [lrmms_pkg::ADDR_W-1:0] rd2_addr,
	output lrmms_pkg::stat_t       rd2_data
);
	import lrmms_pkg::*;

	stat_t                mem_q [MEM_DEPTH];
	logic [MEM_DEPTH-1:0] valid_q;
	stat_t                rd1_q;
	stat_t                rd2_q;

	// An entry that has not been written since its bank was opened reads as
	// the reset statistics.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (clr_en) begin
				for (int i = 0; i < MEM_DEPTH; i++) begin
					if (i / MAX_LANES == int'(clr_bank)) valid_q[i] <= 1'b0;
				end
			end
			if (wr_en) valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_data;
		if (rd1_en) rd1_q <= valid_q[rd1_addr] ? mem_q[rd1_addr] : STAT_RESET;
		if (rd2_en) rd2_q <= valid_q[rd2_addr] ? mem_q[rd2_addr] : STAT_RESET;
	end

	assign rd1_data = rd1_q;
	assign rd2_data = rd2_q;

endmodule

@@ design/lrmms_update.sv @@
// ----------------------------------------------------------------------------
// lrmms_update
// Accepts words, tracks lane and beat position, and updates the lane entry
// by read, modify and write back with forwarding from the previous word.
// ----------------------------------------------------------------------------
module lrmms_update #(
	parameter int LANES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [lrmms_pkg::BEAT_W-1:0]  row_beats,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [lrmms_pkg::WORD_W-1:0]  s_word,
	input  logic                          s_eop,
	input  logic                          drain_busy,
	output lrmms_pkg::drain_start_t       drain_start,
	output logic                          clr_en,
	output logic                          clr_bank,
	output logic                          rd_en,
	output logic [lrmms_pkg::ADDR_W-1:0]  rd_addr,
	input  lrmms_pkg::stat_t              rd_data,
	output logic                          wr_en,
	output logic [lrmms_pkg::ADDR_W-1:0]  wr_addr,
	output lrmms_pkg::stat_t              wr_data
);
	import lrmms_pkg::*;

	logic [LANE_W-1:0] pos_q;
	logic [BEAT_W-1:0] beats_q;
	logic              bank_q;

	logic              vld_s1;
	logic              end_s1;
	logic              eop_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [WORD_W-1:0] word_s1;

	logic              byp_vld_q;
	logic [ADDR_W-1:0] byp_addr_q;
	stat_t             byp_data_q;

	logic              acc;
	logic              lane_last;
	logic [BEAT_W-1:0] done;
	logic [BEAT_W-1:0] need;
	logic              row_end;
	stat_t             old_stat;
	stat_t             new_stat;

	assign lane_last = (pos_q == LANE_W'(LANES - 1));
	assign done      = beats_q + BEAT_W'(1);
	assign need      = (row_beats == '0) ? BEAT_W'(1) : row_beats;
	assign row_end   = lane_last && ((done == '0) || (done >= need));

	// A row-ending word waits until the other bank has been fully read out.
	assign s_tready = !(row_end && ((vld_s1 && end_s1) || drain_busy));
	assign acc      = s_tvalid && s_tready;

	assign rd_en    = acc;
	assign rd_addr  = {bank_q, pos_q};
	assign clr_en   = acc && row_end;
	assign clr_bank = ~bank_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			beats_q   <= '0;
			bank_q    <= 1'b0;
			vld_s1    <= 1'b0;
			byp_vld_q <= 1'b0;
		end else begin
			vld_s1    <= acc;
			byp_vld_q <= vld_s1;
			if (acc) begin
				pos_q <= lane_last ? '0 : pos_q + LANE_W'(1);
				if (lane_last) beats_q <= row_end ? '0 : done;
				if (row_end) bank_q <= ~bank_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			end_s1  <= row_end;
			eop_s1  <= s_eop;
			addr_s1 <= rd_addr;
			word_s1 <= s_word;
		end
		byp_addr_q <= addr_s1;
		byp_data_q <= new_stat;
	end

	// The read for this item was issued while the previous item was writing.
	assign old_stat = (byp_vld_q && (byp_addr_q == addr_s1)) ? byp_data_q : rd_data;

	always_comb begin
		new_stat.max = (word_s1 > old_stat.max) ? word_s1 : old_stat.max;
		new_stat.min = (word_s1 < old_stat.min) ? word_s1 : old_stat.min;
		new_stat.sum = old_stat.sum + SUM_W'(word_s1);
	end

	assign wr_en   = vld_s1;
	assign wr_addr = addr_s1;
	assign wr_data = new_stat;

	assign drain_start.vld  = vld_s1 && end_s1;
	assign drain_start.bank = addr_s1[ADDR_W-1];
	assign drain_start.eop  = eop_s1;

endmodule

@@ design/lrmms_drain.sv @@
// ----------------------------------------------------------------------------
// lrmms_drain
// Reads a finished bank out in lane order and presents one result item
// per lane through a registered output stage.
// ----------------------------------------------------------------------------
module lrmms_drain #(
	parameter int LANES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lrmms_pkg::drain_start_t       drain_start,
	output logic                          drain_busy,
	output logic                          rd_en,
	output logic [lrmms_pkg::ADDR_W-1:0]  rd_addr,
	input  lrmms_pkg::stat_t              rd_data,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [lrmms_pkg::OUT_W-1:0]   m_tdata,
	output logic                          m_tlast,
	output logic                          m_tuser
);
	import lrmms_pkg::*;

	logic              active_q;
	logic [LANE_W-1:0] lane_q;
	logic              bank_q;
	logic              eop_q;

	logic              vld_s1;
	logic [LANE_W-1:0] lane_s1;
	logic              eop_s1;
	logic              last_s1;

	logic              out_vld_q;
	logic [OUT_W-1:0]  out_data_q;
	logic              out_eop_q;
	logic              out_last_q;

	logic              out_adv;
	logic              s1_adv;
	logic              issue;
	logic              lane_last;

	assign out_adv   = !out_vld_q || m_tready;
	assign s1_adv    = !vld_s1 || out_adv;
	assign issue     = active_q && s1_adv;
	assign lane_last = (lane_q == LANE_W'(LANES - 1));

	assign drain_busy = active_q;
	assign rd_en      = issue;
	assign rd_addr    = {bank_q, lane_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			lane_q    <= '0;
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (drain_start.vld) begin
				active_q <= 1'b1;
				lane_q   <= '0;
			end else if (issue) begin
				lane_q <= lane_last ? '0 : lane_q + LANE_W'(1);
				if (lane_last) active_q <= 1'b0;
			end
			if (s1_adv) vld_s1 <= issue;
			if (out_adv) out_vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (drain_start.vld) begin
			bank_q <= drain_start.bank;
			eop_q  <= drain_start.eop;
		end
		if (issue) begin
			lane_s1 <= lane_q;
			eop_s1  <= eop_q;
			last_s1 <= lane_last;
		end
		if (out_adv && vld_s1) begin
			out_data_q <= {{(OUT_W - LANE_W - 2 * WORD_W - SUM_W){1'b0}},
				rd_data.sum, rd_data.min, rd_data.max, lane_s1};
			out_eop_q  <= eop_s1;
			out_last_q <= last_s1;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_eop_q;
	assign m_tuser  = out_last_q;

endmodule

@@ design/lane_row_min_max_sum.sv @@
// ----------------------------------------------------------------------------
// lane_row_min_max_sum
// Per-lane running maximum, minimum and 64-bit sum over rows of words.
// ----------------------------------------------------------------------------
// Words are taken one per cycle; word k of each beat of LANES words feeds
// lane k. Statistics live in a two-bank memory, one bank per row in turn,
// updated by read, modify and write back with forwarding between
// neighboring words. After the last word of the row_beats-th beat the
// finished bank is read out through the second memory port, one result
// item per lane in lane order at up to one per cycle, while the next row
// already fills the other bank. The only input stall is on a row-ending
// word while the previous row's readout has not yet issued all LANES
// reads. The readout starts once the row-ending word has passed the update
// stage register and the drain active flag is set, so with the output
// always ready a single-beat row that follows a row end stalls on its own
// row-ending word, while longer rows do not when LANES is at least two.
// Back-pressure on the output extends the stall.
// m_tlast carries the row's end-of-packet flag and m_tuser marks the
// result for the highest lane. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module lane_row_min_max_sum #(
	parameter int LANES = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [lrmms_pkg::BEAT_W-1:0] cfg_data,     // row_beats
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [31:0]                  s_tdata,      // word_value
	input  logic                         s_tlast,      // end_of_packet
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// lane_index[3:0], row_max[35:4], row_min[67:36], row_sum[131:68], zero pad
	output logic [lrmms_pkg::OUT_W-1:0]  m_tdata,
	output logic                         m_tlast,      // packet_end
	output logic                         m_tuser       // last_lane
);
	import lrmms_pkg::*;

	logic [BEAT_W-1:0] row_beats_q;

	drain_start_t      drain_start;
	logic              drain_busy;
	logic              clr_en;
	logic              clr_bank;
	logic              rd1_en;
	logic [ADDR_W-1:0] rd1_addr;
	stat_t             rd1_data;
	logic              rd2_en;
	logic [ADDR_W-1:0] rd2_addr;
	stat_t             rd2_data;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	stat_t             wr_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_beats_q <= BEAT_W'(1);
		end else if (cfg_we) begin
			row_beats_q <= cfg_data;
		end
	end

	lrmms_stat_mem u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.clr_en   (clr_en),
		.clr_bank (clr_bank),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd1_en   (rd1_en),
		.rd1_addr (rd1_addr),
		.rd1_data (rd1_data),
		.rd2_en   (rd2_en),
		.rd2_addr (rd2_addr),
		.rd2_data (rd2_data)
	);

	lrmms_update #(.LANES(LANES)) u_update (
		.clk         (clk),
		.arst_n      (arst_n),
		.row_beats   (row_beats_q),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_word      (s_tdata),
		.s_eop       (s_tlast),
		.drain_busy  (drain_busy),
		.drain_start (drain_start),
		.clr_en      (clr_en),
		.clr_bank    (clr_bank),
		.rd_en       (rd1_en),
		.rd_addr     (rd1_addr),
		.rd_data     (rd1_data),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data)
	);

	lrmms_drain #(.LANES(LANES)) u_drain (
		.clk         (clk),
		.arst_n      (arst_n),
		.drain_start (drain_start),
		.drain_busy  (drain_busy),
		.rd_en       (rd2_en),
		.rd_addr     (rd2_addr),
		.rd_data     (rd2_data),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast),
		.m_tuser     (m_tuser)
	);

endmodule
